>>> design/assert_macros.svh
// Assertion macros shared by the bitstream field reader RTL.
// Each macro expands to one labeled concurrent assertion with a reset guard (disable iff).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/bfr_pkg.sv
// Package of the bitstream field reader: command codes, field widths and defaults.
// Used by bitstream_field_reader; depends on nothing else.
package bfr_pkg;

   localparam int BUF_BYTES_DEF = 65536;

   localparam int LEN_W   = 17;  // buffer length and byte position
   localparam int CUR_W   = 20;  // bit position: byte and bit
   localparam int ARITH_W = 22;  // position sums with headroom
   localparam int WIN_W   = 72;  // nine fetched bytes
   localparam int WIN_BYTES = 9;
   localparam int GOL_MAX_ZEROS = 31;

   typedef enum logic [3:0] {
      OP_LOAD      = 4'd0,
      OP_READ_U    = 4'd1,
      OP_READ_S    = 4'd2,
      OP_UE        = 4'd3,
      OP_SE        = 4'd4,
      OP_BYTE      = 4'd5,
      OP_ALIGN     = 4'd6,
      OP_ALIGN_N   = 4'd7,
      OP_SEEK      = 4'd8,
      OP_SKIP      = 4'd9,
      OP_CHK_REST  = 4'd10,
      OP_CHK_ALIGN = 4'd11
   } opcode_type;

endpackage

>>> design/bitstream_field_reader.sv
// Bitstream field reader: MSB-first bit reader over a byte buffer held in one RAM.
// Depends on bfr_pkg and assert_macros.svh.
//
// One command is taken at a time and each gives one result beat. Loads, aligns, seeks,
// skips and the rest check go straight to evaluation. Align N and check aligned with a
// nonzero N first run a bit-serial remainder unit. Field, byte and exp-Golomb reads fetch
// nine buffer bytes through the single RAM read port, and a Golomb code then scans its
// prefix one bit per cycle (up to 31 leading zeros) before the suffix step. A result
// waiting on rsp_ready holds the block in its output stage. The buffer RAM needs no
// clearing after reset; bytes are loaded by command.
module bitstream_field_reader
   #(parameter int BUF_BYTES = bfr_pkg::BUF_BYTES_DEF)
   (input  logic        clock,
    input  logic        reset,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [3:0]  req_opcode,
    input  logic [15:0] req_byte_amount,
    input  logic [6:0]  req_bit_amount,
    input  logic [7:0]  req_byte_value,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [63:0] rsp_value,
    output logic        rsp_status,
    output logic        rsp_check_flag,
    output logic [16:0] rsp_position_byte,
    output logic [2:0]  rsp_position_bit,
    input  logic        csr_valid,
    output logic        csr_ready,
    input  logic [16:0] csr_buffer_length);

   import bfr_pkg::*;
`include "assert_macros.svh"

   localparam int AW = (BUF_BYTES > 1) ? $clog2(BUF_BYTES) : 1;
   localparam logic [31:0] BUF_LIM = 32'(BUF_BYTES);
   localparam logic [5:0] ZC_MAX = 6'(GOL_MAX_ZEROS);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FETCH = 8'b0000_0010,
      ST_SHIFT = 8'b0000_0100,
      ST_GZERO = 8'b0000_1000,
      ST_GSUF  = 8'b0001_0000,
      ST_DIV   = 8'b0010_0000,
      ST_EXEC  = 8'b0100_0000,
      ST_PUSH  = 8'b1000_0000
   } state_type;

   logic [7:0] mem [BUF_BYTES];

   state_type state_ff, state_in;
   opcode_type op_ff;
   logic [15:0] nbytes_ff;
   logic [6:0] nbits_ff;
   logic [LEN_W-1:0] len_ff;
   logic [CUR_W-1:0] cur_ff, cur_in;
   logic [WIN_W-1:0] win_ff, sh_ff;
   logic [3:0] fc_ff, nr_ff;
   logic rv_ff;
   logic [7:0] rdata_ff;
   logic [5:0] zc_ff;
   logic gerr_ff;
   logic [63:0] k_ff;
   logic [CUR_W-1:0] gcur_ff;
   logic [LEN_W-1:0] rem_ff;
   logic [4:0] dc_ff;
   logic [63:0] res_val_ff, res_val_in;
   logic res_st_ff, res_st_in, res_flag_ff, res_flag_in;
   logic rsp_valid_ff;
   logic [63:0] rsp_value_ff;
   logic rsp_status_ff, rsp_flag_ff;
   logic [CUR_W-1:0] rsp_cur_ff;

   logic req_fire, rd_en, wr_en, push;
   logic [LEN_W-1:0] len_eff;
   logic [ARITH_W-1:0] curx, endbit, nb8, nbx, q_zero, q_suf;
   logic [AW-1:0] rd_addr;
   logic [6:0] zidx;
   logic [63:0] suf_sh, suf, k_val;
   logic [LEN_W-1:0] div_r2;
   logic [LEN_W:0] align_p;
   logic err_beat;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign push = (state_ff == ST_PUSH) && (!rsp_valid_ff || rsp_ready);

   assign len_eff = ({15'b0, len_ff} > BUF_LIM) ? BUF_LIM[LEN_W-1:0] : len_ff;
   assign curx    = ARITH_W'(cur_ff);
   assign endbit  = ARITH_W'({len_eff, 3'b000});
   assign nb8     = ARITH_W'({nbytes_ff, 3'b000});
   assign nbx     = ARITH_W'(nbits_ff);

   // Buffer RAM: one write port for loads, one registered read port for fetches.
   assign wr_en = req_fire && (opcode_type'(req_opcode) == OP_LOAD)
                  && ({16'b0, req_byte_amount} < BUF_LIM);
   assign rd_en = (state_ff == ST_FETCH) && (fc_ff < 4'(WIN_BYTES));
   assign rd_addr = AW'(ARITH_W'(cur_ff[CUR_W-1:3]) + ARITH_W'(fc_ff));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_byte_amount)] <= req_byte_value;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Golomb prefix scan and suffix extraction.
   assign zidx   = 7'd71 - {1'b0, zc_ff};
   assign q_zero = curx + ARITH_W'(zc_ff);
   assign q_suf  = q_zero + ARITH_W'(1);
   assign suf_sh = sh_ff[WIN_W-1:8] << (zc_ff + 6'd1);
   assign suf    = suf_sh >> (7'd64 - {1'b0, zc_ff});
   assign k_val  = suf + ((64'd1 << zc_ff) - 64'd1);

   // One restoring step of the remainder of the byte position by N.
   always_comb begin
      div_r2 = {rem_ff[15:0], cur_ff[3 + dc_ff]};
      if (div_r2 >= {1'b0, nbytes_ff}) begin
         div_r2 = div_r2 - {1'b0, nbytes_ff};
      end
   end

   assign align_p = {1'b0, cur_ff[CUR_W-1:3]} - {1'b0, rem_ff} + {2'b0, nbytes_ff};

   // Final command evaluation.
   always_comb begin
      logic [ARITH_W-1:0] tgt;
      logic [63:0] rv, smask;
      cur_in      = cur_ff;
      res_val_in  = 64'd0;
      res_st_in   = 1'b0;
      res_flag_in = 1'b0;
      tgt = curx + nb8 + nbx;
      rv = sh_ff[WIN_W-1:8] >> (7'd64 - nbits_ff);
      smask = ~64'd0 << nbits_ff;
      unique case (op_ff)
         OP_LOAD: begin
            res_st_in = ({16'b0, nbytes_ff} >= BUF_LIM);
         end
         OP_READ_U, OP_READ_S: begin
            if (nbits_ff > 7'd64 || curx + nbx > endbit) begin
               res_st_in = 1'b1;
            end else begin
               if (op_ff == OP_READ_S && nbits_ff != 7'd0 && nbits_ff < 7'd64
                   && rv[nbits_ff[5:0] - 6'd1]) begin
                  rv = rv | smask;
               end
               res_val_in = rv;
               cur_in = CUR_W'(curx + nbx);
            end
         end
         OP_UE, OP_SE: begin
            if (gerr_ff) begin
               res_st_in = 1'b1;
            end else begin
               if (op_ff == OP_UE) begin
                  res_val_in = k_ff;
               end else if (k_ff[0]) begin
                  res_val_in = (k_ff >> 1) + 64'd1;
               end else begin
                  res_val_in = 64'd0 - (k_ff >> 1);
               end
               cur_in = gcur_ff;
            end
         end
         OP_BYTE: begin
            if (cur_ff[2:0] != 3'd0 || curx + ARITH_W'(8) > endbit) begin
               res_st_in = 1'b1;
            end else begin
               res_val_in = {56'd0, sh_ff[WIN_W-1:WIN_W-8]};
               cur_in = CUR_W'(curx + ARITH_W'(8));
            end
         end
         OP_ALIGN: begin
            if (cur_ff[CUR_W-1:3] < len_eff && cur_ff[2:0] != 3'd0) begin
               cur_in = {cur_ff[CUR_W-1:3] + 17'd1, 3'b000};
            end
         end
         OP_ALIGN_N: begin
            if (nbytes_ff == 16'd0) begin
               res_st_in = 1'b1;
            end else if (cur_ff[CUR_W-1:3] < len_eff
                         && !(rem_ff == 17'd0 && cur_ff[2:0] == 3'd0)) begin
               if (align_p >= {1'b0, len_eff}) begin
                  res_st_in = 1'b1;
               end else begin
                  cur_in = {align_p[LEN_W-1:0], 3'b000};
               end
            end
         end
         OP_SEEK: begin
            if (nbits_ff > 7'd7 || {1'b0, nbytes_ff} >= len_eff) begin
               res_st_in = 1'b1;
            end else begin
               cur_in = {1'b0, nbytes_ff, nbits_ff[2:0]};
            end
         end
         OP_SKIP: begin
            if (ARITH_W'(tgt[ARITH_W-1:3]) >= ARITH_W'(len_eff)) begin
               res_st_in = 1'b1;
            end else begin
               cur_in = CUR_W'(tgt);
            end
         end
         OP_CHK_REST: begin
            res_flag_in = (tgt <= endbit);
         end
         OP_CHK_ALIGN: begin
            if (nbytes_ff == 16'd0) begin
               res_st_in = 1'b1;
            end else begin
               res_flag_in = (rem_ff == 17'd0) && (cur_ff[2:0] == 3'd0);
            end
         end
         default: begin
            res_st_in = 1'b1;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               priority case (opcode_type'(req_opcode))
                  OP_READ_U, OP_READ_S, OP_UE, OP_SE, OP_BYTE: state_in = ST_FETCH;
                  OP_ALIGN_N, OP_CHK_ALIGN: begin
                     state_in = (req_byte_amount == 16'd0) ? ST_EXEC : ST_DIV;
                  end
                  default: state_in = ST_EXEC;
               endcase
            end
         end
         ST_FETCH: begin
            if (rv_ff && nr_ff == 4'(WIN_BYTES - 1)) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            state_in = (op_ff == OP_UE || op_ff == OP_SE) ? ST_GZERO : ST_EXEC;
         end
         ST_GZERO: begin
            if (q_zero >= endbit) begin
               state_in = ST_EXEC;
            end else if (sh_ff[zidx]) begin
               state_in = ST_GSUF;
            end else if (zc_ff == ZC_MAX) begin
               state_in = ST_EXEC;
            end
         end
         ST_GSUF: state_in = ST_EXEC;
         ST_DIV: begin
            if (dc_ff == 5'd0) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: state_in = ST_PUSH;
         ST_PUSH: begin
            if (push) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         rv_ff        <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rd_en;
         if (csr_valid && csr_ready) begin
            len_ff <= csr_buffer_length;
            cur_ff <= '0;
         end else if (state_ff == ST_EXEC) begin
            cur_ff <= cur_in;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff     <= opcode_type'(req_opcode);
         nbytes_ff <= req_byte_amount;
         nbits_ff  <= req_bit_amount;
         fc_ff     <= '0;
         nr_ff     <= '0;
         zc_ff     <= '0;
         gerr_ff   <= 1'b0;
         rem_ff    <= '0;
         dc_ff     <= 5'd16;
      end
      if (rd_en) begin
         fc_ff <= fc_ff + 4'd1;
      end
      if (rv_ff) begin
         win_ff <= {win_ff[WIN_W-9:0], rdata_ff};
         nr_ff  <= nr_ff + 4'd1;
      end
      if (state_ff == ST_SHIFT) begin
         sh_ff <= win_ff << cur_ff[2:0];
      end
      if (state_ff == ST_GZERO) begin
         if (q_zero >= endbit) begin
            gerr_ff <= 1'b1;
         end else if (!sh_ff[zidx]) begin
            zc_ff <= zc_ff + 6'd1;
            if (zc_ff == ZC_MAX) begin
               gerr_ff <= 1'b1;
            end
         end
      end
      if (state_ff == ST_GSUF) begin
         gerr_ff <= (q_suf + ARITH_W'(zc_ff) > endbit);
         k_ff    <= k_val;
         gcur_ff <= CUR_W'(q_suf + ARITH_W'(zc_ff));
      end
      if (state_ff == ST_DIV) begin
         rem_ff <= div_r2;
         dc_ff  <= dc_ff - 5'd1;
      end
      if (state_ff == ST_EXEC) begin
         res_val_ff  <= res_st_in ? 64'd0 : res_val_in;
         res_st_ff   <= res_st_in;
         res_flag_ff <= res_flag_in;
      end
      if (push) begin
         rsp_value_ff  <= res_val_ff;
         rsp_status_ff <= res_st_ff;
         rsp_flag_ff   <= res_flag_ff;
         rsp_cur_ff    <= cur_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_check_flag    = rsp_flag_ff;
   assign rsp_position_byte = rsp_cur_ff[CUR_W-1:3];
   assign rsp_position_bit  = rsp_cur_ff[2:0];

   assign err_beat = rsp_valid_ff && rsp_status_ff;

   `BFR_ASSERT_NOW(a_state_onehot, clock, reset, 1'b1, $onehot(state_ff), "state not one-hot")
   `BFR_ASSERT_NOW(a_pos_in_buf, clock, reset, 1'b1, curx <= endbit, "position past buffer end")
   `BFR_ASSERT_NOW(a_err_zero, clock, reset, err_beat, rsp_value_ff == 64'd0, "value on error")
   `BFR_ASSERT_NEXT(a_req_busy, clock, reset, req_fire, state_ff != ST_IDLE, "idle after accept")
   `BFR_ASSERT_NOW(a_zc_range, clock, reset, state_ff == ST_GZERO, zc_ff <= ZC_MAX, "bad prefix")

endmodule
